// ===== src/icm_pkg.sv =====
// Shared constants, register indexes and types of the intensity colormap block.
`default_nettype none

package icm_pkg;

    // Default number of fraction bits of the normalized intensity.
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths.
    localparam int INT_W      = 21;
    localparam int MAG_W      = INT_W + 1;
    localparam int CH_W       = 8;
    localparam int COLOR_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Clamp limits of the running bounds and their reset values.
    localparam logic signed [INT_W-1:0] BOUND_HI = 21'sd999999;
    localparam logic signed [INT_W-1:0] BOUND_LO = -21'sd999999;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RAINBOW_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_BOUNDS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_COLOR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_COLOR   = 3'd5;

    // Configuration register reset values.
    localparam logic signed [INT_W-1:0] MANUAL_MIN_RST = 21'sd0;
    localparam logic signed [INT_W-1:0] MANUAL_MAX_RST = 21'sd4096;
    localparam logic [COLOR_W-1:0]      LOW_COLOR_RST  = 24'h000000;
    localparam logic [COLOR_W-1:0]      HIGH_COLOR_RST = 24'hFFFFFF;

    // Input command codes.
    localparam logic CMD_BOUNDS = 1'b0;
    localparam logic CMD_COLOR  = 1'b1;

    // Settings seen by the shading unit.
    typedef struct packed {
        logic               rainbow_mode;
        logic [COLOR_W-1:0] low_color;
        logic [COLOR_W-1:0] high_color;
    } t_shade_cfg;

    // Request to the divider: start strobe with numerator and denominator magnitudes.
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] num;
        logic [MAG_W-1:0] den;
    } t_div_req;

endpackage

`default_nettype wire

// ===== src/icm_if.sv =====
// Valid/ready channel interfaces for input items, result items and configuration writes.
`default_nettype none

interface icm_in_if;
    import icm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic                    first;
    logic signed [INT_W-1:0] intensity;

    modport source (output valid, output cmd, output first, output intensity, input ready);
    modport sink   (input valid, input cmd, input first, input intensity, output ready);
endinterface

interface icm_out_if;
    import icm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CH_W-1:0]         red;
    logic [CH_W-1:0]         green;
    logic [CH_W-1:0]         blue;
    logic signed [INT_W-1:0] bound_low;
    logic signed [INT_W-1:0] bound_high;

    modport source (output valid, output red, output green, output blue,
                    output bound_low, output bound_high, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input bound_low, input bound_high, output ready);
endinterface

interface icm_cfg_if;
    import icm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/icm_divider.sv =====
// Radix-2 restoring divider that produces one fraction bit per cycle.
`default_nettype none

module icm_divider #(
    parameter int FRAC_BITS = icm_pkg::FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire icm_pkg::t_div_req i_req,
    output logic                   o_done,
    output logic [FRAC_BITS-1:0]   o_quot
);
    import icm_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [MAG_W-1:0]   r_rem;
    logic [MAG_W-1:0]   r_den;
    logic [FRAC_BITS-1:0] r_quot;

    logic [MAG_W:0] shifted;
    logic [MAG_W:0] diff;
    logic           q_bit;

    // The remainder stays below the denominator, so the shift never loses a bit.
    assign shifted = {r_rem, 1'b0};
    assign diff    = shifted - {1'b0, r_den};
    assign q_bit   = (shifted >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= q_bit ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
            r_quot <= {r_quot[FRAC_BITS-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== src/icm_shade.sv =====
// Shading unit: rainbow ramp or two-color blend through one shared multiply-accumulate.
`default_nettype none

module icm_shade #(
    parameter int FRAC_BITS = icm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [FRAC_BITS:0]  i_frac,
    input  wire icm_pkg::t_shade_cfg i_cfg,
    output logic                     o_done,
    output logic [icm_pkg::CH_W-1:0] o_red,
    output logic [icm_pkg::CH_W-1:0] o_green,
    output logic [icm_pkg::CH_W-1:0] o_blue
);
    import icm_pkg::*;

    localparam int HW    = FRAC_BITS + 4;
    localparam int ACC_W = FRAC_BITS + CH_W + 1;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    logic             r_busy;
    logic             r_done;
    logic [1:0]       r_ch;
    logic             r_phase;
    logic [ACC_W-1:0] r_acc;
    logic [CH_W-1:0]  r_red;
    logic [CH_W-1:0]  r_green;
    logic [CH_W-1:0]  r_blue;

    logic [FRAC_BITS:0] v;
    logic [HW-1:0]      h;
    logic [3:0]         seg;
    logic [FRAC_BITS:0] f_raw;
    logic [FRAC_BITS:0] f;
    logic [FRAC_BITS:0] n;
    logic [FRAC_BITS:0] rain_r;
    logic [FRAC_BITS:0] rain_g;
    logic [FRAC_BITS:0] rain_b;

    logic [CH_W-1:0]    op_a;
    logic [FRAC_BITS:0] op_b;
    logic [CH_W-1:0]    hc_ch;
    logic [CH_W-1:0]    lc_ch;
    logic [FRAC_BITS:0] rain_ch;
    logic [ACC_W-1:0]   prod;
    logic [ACC_W-1:0]   sum;
    logic [CH_W-1:0]    ch_byte;
    logic               last_of_ch;

    // Five-segment hue ramp over one minus the fraction.
    always_comb begin
        v     = ONE - i_frac;
        h     = ({3'b000, v} << 2) + {3'b000, v} + {3'b000, ONE};
        seg   = h[FRAC_BITS+3:FRAC_BITS];
        f_raw = {1'b0, h[FRAC_BITS-1:0]};
        f     = seg[0] ? f_raw : (ONE - f_raw);
        n     = ONE - f;
        case (seg) inside
            [4'd0:4'd1]: begin
                rain_r = n;    rain_g = '0;   rain_b = ONE;
            end
            4'd2: begin
                rain_r = '0;   rain_g = n;    rain_b = ONE;
            end
            4'd3: begin
                rain_r = '0;   rain_g = ONE;  rain_b = n;
            end
            4'd4: begin
                rain_r = n;    rain_g = ONE;  rain_b = '0;
            end
            default: begin
                rain_r = ONE;  rain_g = n;    rain_b = '0;
            end
        endcase
    end

    always_comb begin
        case (r_ch)
            CH_RED: begin
                hc_ch   = i_cfg.high_color[23:16];
                lc_ch   = i_cfg.low_color[23:16];
                rain_ch = rain_r;
            end
            CH_GREEN: begin
                hc_ch   = i_cfg.high_color[15:8];
                lc_ch   = i_cfg.low_color[15:8];
                rain_ch = rain_g;
            end
            default: begin
                hc_ch   = i_cfg.high_color[7:0];
                lc_ch   = i_cfg.low_color[7:0];
                rain_ch = rain_b;
            end
        endcase

        if (i_cfg.rainbow_mode) begin
            op_a = 8'd255;
            op_b = rain_ch;
        end else if (!r_phase) begin
            op_a = hc_ch;
            op_b = i_frac;
        end else begin
            op_a = lc_ch;
            op_b = ONE - i_frac;
        end

        prod       = ACC_W'(op_a) * ACC_W'(op_b);
        sum        = (r_phase ? r_acc : '0) + prod;
        ch_byte    = sum[FRAC_BITS+CH_W-1:FRAC_BITS];
        last_of_ch = i_cfg.rainbow_mode || r_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_ch    <= CH_RED;
            r_phase <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_ch    <= CH_RED;
                r_phase <= 1'b0;
            end else if (r_busy) begin
                if (last_of_ch) begin
                    r_phase <= 1'b0;
                    if (r_ch == CH_BLUE) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_ch <= r_ch + 2'd1;
                    end
                end else begin
                    r_phase <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_acc <= sum;
            if (last_of_ch) begin
                case (r_ch)
                    CH_RED:   r_red   <= ch_byte;
                    CH_GREEN: r_green <= ch_byte;
                    default:  r_blue  <= ch_byte;
                endcase
            end
        end
    end

    assign o_done  = r_done;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire

// ===== src/intensity_colormap_core.sv =====
// Top level of the intensity colormap: bounds tracking, sequencer, divider and shading unit.
`default_nettype none

// Intensity colormap core. A bounds item (cmd 0) folds its sample into the running minimum
// and maximum in the cycle it is accepted and produces no result; its first flag restarts
// the pair before the fold, and the pair stays clamped to plus or minus 999999. A color item
// (cmd 1) is normalized against the running pair or the manual bounds, turned into a
// fraction by a radix-2 divider, and shaded through a rainbow ramp or a two-color blend by
// one shared multiply-accumulate. The port is busy while a color item is in work: the
// item is accepted, passes sign and range checks in S_PREP and S_CHECK, runs through the
// divider (skipped when the fraction is known to be 0 or 1), is shaded in rainbow or blend
// mode, and is handed to the output register in S_DONE. Bounds items are taken one per
// cycle while no color item is in work. The result waits in an output register, so the
// next item is taken while a finished color is not yet collected. Configuration writes
// are always accepted and must arrive only while the block is idle.
module intensity_colormap_core #(
    parameter int FRAC_BITS = icm_pkg::FRAC_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    icm_in_if.sink     i_in,
    icm_out_if.source  o_out,
    icm_cfg_if.sink    i_cfg
);
    import icm_pkg::*;

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CHECK,
        S_DIV,
        S_SHADE,
        S_DONE
    } t_state;

    // Configuration registers.
    logic                    r_rainbow_mode;
    logic                    r_auto_bounds;
    logic signed [INT_W-1:0] r_manual_min;
    logic signed [INT_W-1:0] r_manual_max;
    logic [COLOR_W-1:0]      r_low_color;
    logic [COLOR_W-1:0]      r_high_color;

    // Sequencer state and work registers.
    t_state                  r_state,      n_state;
    logic signed [INT_W-1:0] r_run_min,    n_run_min;
    logic signed [INT_W-1:0] r_run_max,    n_run_max;
    logic signed [MAG_W-1:0] r_num,        n_num;
    logic signed [MAG_W-1:0] r_den,        n_den;
    logic signed [INT_W-1:0] r_lo,         n_lo;
    logic signed [INT_W-1:0] r_hi,         n_hi;
    logic [MAG_W-1:0]        r_an,         n_an;
    logic [MAG_W-1:0]        r_ad,         n_ad;
    logic                    r_zero,       n_zero;
    logic [FRAC_BITS:0]      r_frac,       n_frac;
    logic                    r_div_start,  n_div_start;
    logic                    r_shade_start, n_shade_start;
    logic                    r_out_valid,  n_out_valid;
    logic [CH_W-1:0]         r_out_red,    n_out_red;
    logic [CH_W-1:0]         r_out_green,  n_out_green;
    logic [CH_W-1:0]         r_out_blue,   n_out_blue;
    logic signed [INT_W-1:0] r_out_lo,     n_out_lo;
    logic signed [INT_W-1:0] r_out_hi,     n_out_hi;

    logic                    in_ready;
    logic                    in_accept;
    logic signed [INT_W-1:0] sel_lo;
    logic signed [INT_W-1:0] sel_hi;
    logic signed [INT_W-1:0] base_min;
    logic signed [INT_W-1:0] base_max;
    logic signed [INT_W-1:0] cand_min;
    logic signed [INT_W-1:0] cand_max;

    t_div_req             div_req;
    logic                 div_done;
    logic [FRAC_BITS-1:0] div_quot;
    t_shade_cfg           shade_cfg;
    logic                 shade_done;
    logic [CH_W-1:0]      shade_red;
    logic [CH_W-1:0]      shade_green;
    logic [CH_W-1:0]      shade_blue;

    // Configuration port: writes land at once; an index beyond the list is dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rainbow_mode <= 1'b1;
            r_auto_bounds  <= 1'b1;
            r_manual_min   <= MANUAL_MIN_RST;
            r_manual_max   <= MANUAL_MAX_RST;
            r_low_color    <= LOW_COLOR_RST;
            r_high_color   <= HIGH_COLOR_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_RAINBOW_MODE: r_rainbow_mode <= i_cfg.data[0];
                REG_AUTO_BOUNDS:  r_auto_bounds  <= i_cfg.data[0];
                REG_MANUAL_MIN:   r_manual_min   <= i_cfg.data[INT_W-1:0];
                REG_MANUAL_MAX:   r_manual_max   <= i_cfg.data[INT_W-1:0];
                REG_LOW_COLOR:    r_low_color    <= i_cfg.data[COLOR_W-1:0];
                REG_HIGH_COLOR:   r_high_color   <= i_cfg.data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_ready   = (r_state == S_IDLE);
    assign i_in.ready = in_ready;
    assign in_accept  = i_in.valid && in_ready;

    // Bounds used by a color item, and the running pair after a bounds item.
    always_comb begin
        sel_lo   = r_auto_bounds ? r_run_min : r_manual_min;
        sel_hi   = r_auto_bounds ? r_run_max : r_manual_max;
        base_min = i_in.first ? BOUND_HI : r_run_min;
        base_max = i_in.first ? BOUND_LO : r_run_max;
        cand_min = (i_in.intensity < base_min) ? i_in.intensity : base_min;
        cand_max = (i_in.intensity > base_max) ? i_in.intensity : base_max;
    end

    always_comb begin
        n_state       = r_state;
        n_run_min     = r_run_min;
        n_run_max     = r_run_max;
        n_num         = r_num;
        n_den         = r_den;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_an          = r_an;
        n_ad          = r_ad;
        n_zero        = r_zero;
        n_frac        = r_frac;
        n_div_start   = 1'b0;
        n_shade_start = 1'b0;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_red     = r_out_red;
        n_out_green   = r_out_green;
        n_out_blue    = r_out_blue;
        n_out_lo      = r_out_lo;
        n_out_hi      = r_out_hi;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in.cmd == CMD_BOUNDS) begin
                        n_run_min = (cand_min < BOUND_LO) ? BOUND_LO : cand_min;
                        n_run_max = (cand_max > BOUND_HI) ? BOUND_HI : cand_max;
                    end else begin
                        // Both differences fit one bit more than the fields.
                        n_num   = {i_in.intensity[INT_W-1], i_in.intensity}
                                  - {sel_lo[INT_W-1], sel_lo};
                        n_den   = {sel_hi[INT_W-1], sel_hi} - {sel_lo[INT_W-1], sel_lo};
                        n_lo    = sel_lo;
                        n_hi    = sel_hi;
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                // A zero or a sign mismatch means the fraction clamps to zero.
                n_an    = r_num[MAG_W-1] ? MAG_W'(-r_num) : MAG_W'(r_num);
                n_ad    = r_den[MAG_W-1] ? MAG_W'(-r_den) : MAG_W'(r_den);
                n_zero  = (r_num == '0) || (r_den == '0) || (r_num[MAG_W-1] != r_den[MAG_W-1]);
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_zero) begin
                    n_frac        = '0;
                    n_shade_start = 1'b1;
                    n_state       = S_SHADE;
                end else if (r_an >= r_ad) begin
                    n_frac        = ONE;
                    n_shade_start = 1'b1;
                    n_state       = S_SHADE;
                end else begin
                    n_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_frac        = {1'b0, div_quot};
                    n_shade_start = 1'b1;
                    n_state       = S_SHADE;
                end
            end
            S_SHADE: begin
                if (shade_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Load the output register once it is empty or being emptied.
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_red   = shade_red;
                    n_out_green = shade_green;
                    n_out_blue  = shade_blue;
                    n_out_lo    = r_lo;
                    n_out_hi    = r_hi;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_run_min     <= BOUND_HI;
            r_run_max     <= BOUND_LO;
            r_div_start   <= 1'b0;
            r_shade_start <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_run_min     <= n_run_min;
            r_run_max     <= n_run_max;
            r_div_start   <= n_div_start;
            r_shade_start <= n_shade_start;
            r_out_valid   <= n_out_valid;
        end
        r_num       <= n_num;
        r_den       <= n_den;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_an        <= n_an;
        r_ad        <= n_ad;
        r_zero      <= n_zero;
        r_frac      <= n_frac;
        r_out_red   <= n_out_red;
        r_out_green <= n_out_green;
        r_out_blue  <= n_out_blue;
        r_out_lo    <= n_out_lo;
        r_out_hi    <= n_out_hi;
    end

    assign div_req.start = r_div_start;
    assign div_req.num   = r_an;
    assign div_req.den   = r_ad;

    icm_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign shade_cfg.rainbow_mode = r_rainbow_mode;
    assign shade_cfg.low_color    = r_low_color;
    assign shade_cfg.high_color   = r_high_color;

    icm_shade #(
        .FRAC_BITS (FRAC_BITS)
    ) u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_shade_start),
        .i_frac  (r_frac),
        .i_cfg   (shade_cfg),
        .o_done  (shade_done),
        .o_red   (shade_red),
        .o_green (shade_green),
        .o_blue  (shade_blue)
    );

    assign o_out.valid      = r_out_valid;
    assign o_out.red        = r_out_red;
    assign o_out.green      = r_out_green;
    assign o_out.blue       = r_out_blue;
    assign o_out.bound_low  = r_out_lo;
    assign o_out.bound_high = r_out_hi;

endmodule

`default_nettype wire

// ===== src/icm_checker.sv =====
// Port-level assertions for the intensity colormap core and the bind that attaches them.
`default_nettype none

module icm_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_in_cmd,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [icm_pkg::CH_W-1:0]      i_out_red,
    input wire logic [icm_pkg::CH_W-1:0]      i_out_green,
    input wire logic [icm_pkg::CH_W-1:0]      i_out_blue,
    input wire logic signed [icm_pkg::INT_W-1:0] i_out_bound_low,
    input wire logic signed [icm_pkg::INT_W-1:0] i_out_bound_high
);
    import icm_pkg::*;

    // A result stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_red) && $stable(i_out_green)
            && $stable(i_out_blue) && $stable(i_out_bound_low) && $stable(i_out_bound_high))
        else $error("stalled result changed");

    // A color item keeps the input port busy in the following cycle.
    a_color_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd == CMD_COLOR) |=> !i_in_ready)
        else $error("input taken right after a color item");

    // A bounds item never creates a result.
    a_bounds_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd == CMD_BOUNDS) && !i_out_valid
            |=> !i_out_valid)
        else $error("bounds item produced a result");

endmodule

bind intensity_colormap_core icm_checker u_icm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_cmd         (i_in.cmd),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_red        (o_out.red),
    .i_out_green      (o_out.green),
    .i_out_blue       (o_out.blue),
    .i_out_bound_low  (o_out.bound_low),
    .i_out_bound_high (o_out.bound_high)
);

`default_nettype wire
